>>> rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

    // Fixed field widths of the stream payload
    localparam int POS_W = 5;
    localparam int LEN_W = 5;

    // Operation codes carried on the input tuser
    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DISPLAY   = 3'd6
    } op_t;

    // Result status codes carried on the output tuser
    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_BADPOS = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

endpackage

>>> rtl/ple_cell.sv
// One storage cell of the list chain: holds one element and shifts with its neighbors.
`timescale 1ns / 1ps

module ple_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                    clk,
    input  ple_pkg::cell_op_t       cell_op,
    input  logic [IDX_W-1:0]        sel_idx,    // insert or delete index
    input  logic [IDX_W-1:0]        wrap_idx,   // index of the last element
    input  logic [DATA_WIDTH-1:0]   ins_data,   // value written on insert
    input  logic [DATA_WIDTH-1:0]   left_data,  // neighbor at INDEX-1
    input  logic [DATA_WIDTH-1:0]   right_data, // neighbor at INDEX+1
    input  logic [DATA_WIDTH-1:0]   head_data,  // cell 0, for rotation wrap
    output logic [DATA_WIDTH-1:0]   data
);

    import ple_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Pick the next value from the broadcast command and this cell's place
    always_comb
    begin
        data_next = data_reg;
        case (cell_op)
            CELL_INS:
            begin
                if (MY_IDX > sel_idx)
                    data_next = left_data;
                else if (MY_IDX == sel_idx)
                    data_next = ins_data;
            end
            CELL_DEL:
            begin
                if (MY_IDX >= sel_idx)
                    data_next = right_data;
            end
            CELL_ROT:
            begin
                if (MY_IDX < wrap_idx)
                    data_next = right_data;
                else if (MY_IDX == wrap_idx)
                    data_next = head_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Hold the element
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> rtl/positional_list_engine_core.sv
// Top level of the positional list engine: command decode, fill count and the cell chain.
`timescale 1ns / 1ps
//
// Usage:
//   The slave stream takes one operation per transaction: s_tuser is the
//   opcode, s_tdata carries the value to insert and a one-based position.
//   The master stream returns results: m_tuser is the status, m_tdata the
//   element and the list length after the operation, m_tlast marks the
//   final result of an operation.
//   Insert and delete shift the row of cells by one place; the result is
//   captured in the output register in the cycle after the transaction,
//   and a new operation is taken in the same cycle the previous result is
//   taken, so while the receiver takes every result these run at one operation per cycle.
//   Display rotates the chain by one cell per result and emits one element
//   per result while no new operation is taken; after as many rotations
//   as there are elements the list is back in its original order.
//   A stalled receiver holds the output register and with it the chain.
//   Reset clears the element count and the output valid; cell contents are
//   left as they are and are never read before they are written.
//
module positional_list_engine_core #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    // value [DATA_WIDTH-1:0], position [DATA_WIDTH+4:DATA_WIDTH], zero pad
    input  logic [((DATA_WIDTH + ple_pkg::POS_W + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode [2:0]
    input  logic [2:0] s_tuser,
    input  logic       s_tvalid,
    output logic       s_tready,
    // element [DATA_WIDTH-1:0], length [DATA_WIDTH+4:DATA_WIDTH], zero pad
    output logic [((DATA_WIDTH + ple_pkg::LEN_W + 7) / 8) * 8 - 1:0] m_tdata,
    // status [1:0]
    output logic [1:0] m_tuser,
    output logic       m_tlast,
    output logic       m_tvalid,
    input  logic       m_tready
);

    import ple_pkg::*;

    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int FILL_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W     = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;
    localparam int M_TDATA_W = ((DATA_WIDTH + LEN_W + 7) / 8) * 8;

    typedef enum logic {
        ST_IDLE,
        ST_DISPLAY
    } state_t;

    state_t                 state_reg,  state_next;
    logic [FILL_W-1:0]      fill_reg,   fill_next;
    logic [FILL_W-1:0]      cnt_reg,    cnt_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [DATA_WIDTH-1:0]  out_elem_reg,   out_elem_next;
    logic [LEN_W-1:0]       out_len_reg,    out_len_next;
    logic                   out_last_reg,   out_last_next;

    cell_op_t               cell_op;
    logic [IDX_W-1:0]       sel_idx;
    logic [IDX_W-1:0]       wrap_idx;
    logic [DATA_WIDTH-1:0]  cell_q [CAPACITY];

    logic                   out_free;
    logic                   accept_in;
    op_t                    in_op;
    logic [DATA_WIDTH-1:0]  in_value;
    logic [CMP_W-1:0]       pos_w;
    logic [CMP_W-1:0]       fill_w;
    logic                   is_full;
    logic                   is_empty;

    // Unpack the input transaction
    assign in_op    = op_t'(s_tuser);
    assign in_value = s_tdata[DATA_WIDTH-1:0];
    assign pos_w    = CMP_W'(s_tdata[DATA_WIDTH + POS_W - 1:DATA_WIDTH]);
    assign fill_w   = CMP_W'(fill_reg);
    assign is_full  = (fill_reg == FILL_W'(CAPACITY));
    assign is_empty = (fill_reg == '0);
    assign wrap_idx = IDX_W'(fill_reg - 1'b1);

    // Handshake: take an operation only when idle and the output slot frees up
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept_in = s_tvalid && s_tready;

    // Decode the operation, drive the chain and form the next result
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_elem_next   = out_elem_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        cell_op         = CELL_HOLD;
        sel_idx         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_elem_next   = '0;
                    out_last_next   = 1'b1;
                    unique case (in_op) inside
                        OP_INS_FRONT, OP_INS_BACK:
                        begin
                            if (is_full)
                                out_status_next = STAT_FULL;
                            else
                            begin
                                cell_op   = CELL_INS;
                                sel_idx   = (in_op == OP_INS_FRONT) ? '0
                                                                    : IDX_W'(fill_reg);
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_INS_AT:
                        begin
                            if (pos_w == '0 || pos_w > fill_w + CMP_W'(1))
                                out_status_next = STAT_BADPOS;
                            else if (is_full)
                                out_status_next = STAT_FULL;
                            else
                            begin
                                cell_op   = CELL_INS;
                                sel_idx   = IDX_W'(pos_w - CMP_W'(1));
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_BACK:
                        begin
                            if (is_empty)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                cell_op   = CELL_DEL;
                                sel_idx   = (in_op == OP_DEL_FRONT) ? '0 : wrap_idx;
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OP_DEL_AT:
                        begin
                            if (is_empty)
                                out_status_next = STAT_EMPTY;
                            else if (pos_w == '0 || pos_w > fill_w)
                                out_status_next = STAT_BADPOS;
                            else
                            begin
                                cell_op   = CELL_DEL;
                                sel_idx   = IDX_W'(pos_w - CMP_W'(1));
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        OP_DISPLAY:
                        begin
                            if (is_empty)
                                out_status_next = STAT_EMPTY;
                            else
                            begin
                                // Emit the head and rotate the chain by one
                                cell_op       = CELL_ROT;
                                out_elem_next = cell_q[0];
                                out_last_next = (fill_reg == FILL_W'(1));
                                cnt_next      = FILL_W'(1);
                                if (fill_reg != FILL_W'(1))
                                    state_next = ST_DISPLAY;
                            end
                        end
                        default:
                        begin
                            out_status_next = STAT_OK;
                        end
                    endcase
                    out_len_next = LEN_W'(fill_next);
                end
            end
            ST_DISPLAY:
            begin
                if (out_free)
                begin
                    cell_op         = CELL_ROT;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_elem_next   = cell_q[0];
                    out_len_next    = LEN_W'(fill_reg);
                    out_last_next   = (FILL_W'(cnt_reg + 1'b1) == fill_reg);
                    cnt_next        = FILL_W'(cnt_reg + 1'b1);
                    if (FILL_W'(cnt_reg + 1'b1) == fill_reg)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, count and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
            out_elem_reg   <= '0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_elem_reg   <= out_elem_next;
            out_len_reg    <= out_len_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Row of cells, each linked to its left and right neighbor
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (gi == 0)
        begin : g_first
            assign left_d = in_value;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[gi - 1];
        end

        if (gi == CAPACITY - 1)
        begin : g_last
            assign right_d = cell_q[gi];
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[gi + 1];
        end

        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .INDEX      (gi)
        ) u_cell (
            .clk        (clk),
            .cell_op    (cell_op),
            .sel_idx    (sel_idx),
            .wrap_idx   (wrap_idx),
            .ins_data   (in_value),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (cell_q[0]),
            .data       (cell_q[gi])
        );
    end

    // Pack the output transaction
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = M_TDATA_W'({out_len_reg, out_elem_reg});

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CAPACITY))
        else $error("element count above capacity");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (fill_reg == $past(fill_reg)
               || fill_reg == FILL_W'($past(fill_reg) + 1'b1)
               || fill_reg == FILL_W'($past(fill_reg) - 1'b1)))
        else $error("element count moved by more than one");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_in && is_full
         && (in_op == OP_INS_FRONT || in_op == OP_INS_BACK || in_op == OP_INS_AT))
        |=> $stable(fill_reg))
        else $error("insert into full list changed the count");

    a_disp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DISPLAY) |-> (cnt_reg < fill_reg && !s_tready))
        else $error("display count out of range or input taken during display");

endmodule
